// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

   // Number format
   localparam int FRACTION_BITS = 8;
   localparam int DATA_W        = 32;
   localparam int NUM_W         = DATA_W + FRACTION_BITS;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int KIND_W        = 4;
   localparam int STATUS_W      = 2;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_ADD      = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SUB      = 4'd1;
   localparam logic [KIND_W-1:0] KIND_MUL      = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DIV      = 4'd3;
   localparam logic [KIND_W-1:0] KIND_MIN      = 4'd4;
   localparam logic [KIND_W-1:0] KIND_MAX      = 4'd5;
   localparam logic [KIND_W-1:0] KIND_INC      = 4'd6;
   localparam logic [KIND_W-1:0] KIND_DEC      = 4'd7;
   localparam logic [KIND_W-1:0] KIND_FROM_INT = 4'd8;
   localparam logic [KIND_W-1:0] KIND_TO_INT   = 4'd9;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIV0 = 2'd2;

   // Saturation limits
   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Fields that ride alongside the divider
   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [DATA_W-1:0]   simple_result;
      logic [STATUS_W-1:0]        simple_status;
      logic                       a_less;
      logic                       a_greater;
      logic                       a_equal;
      logic signed [PROD_W-1:0]   product;
      logic                       div_neg;
      logic                       div_zero;
   } fpa_side_type;

   // One finished result transaction
   typedef struct packed {
      logic signed [DATA_W-1:0]   result;
      logic                       a_less;
      logic                       a_greater;
      logic                       a_equal;
      logic [STATUS_W-1:0]        status;
   } fpa_rsp_type;

endpackage

// ===== rtl/fixed_point_alu_unit.sv =====
// Signed fixed-point ALU, 32-bit raw values with FRACTION_BITS fraction bits.
// Request channel: req_valid / req_stall with req_kind, req_operand_a and
// req_operand_b. A transaction is taken when req_valid is high and req_stall
// is low. Response channel: rsp_valid / rsp_stall with rsp_result, the three
// comparison flags and rsp_status (ok, saturated, divide by zero).
// Every opcode goes through the same pipe: one operand stage, one stage per
// quotient bit of the restoring divider (32 + FRACTION_BITS stages), and a
// two-entry output queue whose input takes the final rounding and
// saturation. A result is registered through the operand stage, every
// divider stage and the queue before rsp_valid; a new transaction is
// accepted in every cycle while req_stall is low.
// Reset clears all valid bits and the queue; no response is pending after it.
// When the receiver stalls, the queue holds the waiting result and takes one
// more; once it is full req_stall rises and the whole pipe holds, so nothing
// is lost or repeated. Results come back in request order.
module fixed_point_alu_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fpa_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [fpa_pkg::DATA_W-1:0]   req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0]   req_operand_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fpa_pkg::DATA_W-1:0]   rsp_result,
   output logic                                rsp_a_less,
   output logic                                rsp_a_greater,
   output logic                                rsp_a_equal,
   output logic [fpa_pkg::STATUS_W-1:0]        rsp_status
);

   logic                            enable;
   logic                            prep_valid;
   fpa_pkg::fpa_side_type           prep_side;
   logic [fpa_pkg::NUM_W-1:0]       prep_num;
   logic [fpa_pkg::DATA_W-1:0]      prep_den;
   logic                            div_valid;
   fpa_pkg::fpa_side_type           div_side;
   logic [fpa_pkg::NUM_W-1:0]       div_quot;
   fpa_pkg::fpa_rsp_type            fin_rsp;
   fpa_pkg::fpa_rsp_type            head;
   logic                            has_room;
   logic                            pop;

   // Advance the whole pipe while the queue has room
   assign enable    = has_room;
   assign req_stall = !has_room;
   assign pop       = rsp_valid && !rsp_stall;

   fpa_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_valid),
      .in_kind  (req_kind),
      .in_a     (req_operand_a),
      .in_b     (req_operand_b),
      .valid_ff (prep_valid),
      .side_ff  (prep_side),
      .num_ff   (prep_num),
      .den_ff   (prep_den)
   );

   fpa_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (prep_valid),
      .in_side   (prep_side),
      .in_num    (prep_num),
      .in_den    (prep_den),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quot  (div_quot)
   );

   fpa_finish u_finish (
      .side (div_side),
      .quot (div_quot),
      .rsp  (fin_rsp)
   );

   fpa_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (div_valid && enable),
      .push_data  (fin_rsp),
      .pop        (pop),
      .has_room   (has_room),
      .head_valid (rsp_valid),
      .head_data  (head)
   );

   assign rsp_result    = head.result;
   assign rsp_a_less    = head.a_less;
   assign rsp_a_greater = head.a_greater;
   assign rsp_a_equal   = head.a_equal;
   assign rsp_status    = head.status;

endmodule

// ===== rtl/fpa_prep.sv =====
module fpa_prep (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic [fpa_pkg::KIND_W-1:0]          in_kind,
   input  logic signed [fpa_pkg::DATA_W-1:0]   in_a,
   input  logic signed [fpa_pkg::DATA_W-1:0]   in_b,
   output logic                                valid_ff,
   output fpa_pkg::fpa_side_type               side_ff,
   output logic [fpa_pkg::NUM_W-1:0]           num_ff,
   output logic [fpa_pkg::DATA_W-1:0]          den_ff
);

   localparam int DW = fpa_pkg::DATA_W;
   localparam int FB = fpa_pkg::FRACTION_BITS;

   logic signed [DW:0]       add_s;
   logic signed [DW:0]       sub_s;
   logic signed [DW:0]       inc_s;
   logic signed [DW:0]       dec_s;
   logic [FB:0]              from_hi;
   logic                     from_ovf;
   logic                     lt;
   logic                     gt;
   logic [DW-1:0]            a_mag;
   logic [DW-1:0]            b_mag;
   fpa_pkg::fpa_side_type    side_in;
   logic [fpa_pkg::NUM_W-1:0] num_in;

   // Saturate a one-bit-wider sum to the data range
   function automatic logic signed [DW-1:0] clamp_sum(input logic signed [DW:0] s);
      if (s[DW] != s[DW-1]) begin
         clamp_sum = s[DW] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
      end else begin
         clamp_sum = s[DW-1:0];
      end
   endfunction

   // Sums and comparison
   assign add_s   = {in_a[DW-1], in_a} + {in_b[DW-1], in_b};
   assign sub_s   = {in_a[DW-1], in_a} - {in_b[DW-1], in_b};
   assign inc_s   = {in_a[DW-1], in_a} + (DW+1)'(1);
   assign dec_s   = {in_a[DW-1], in_a} - (DW+1)'(1);
   assign lt      = in_a < in_b;
   assign gt      = in_a > in_b;
   assign from_hi = in_a[DW-1 -: FB+1];
   assign from_ovf = !((&from_hi) || !(|from_hi));

   // Divider operands as magnitudes
   assign a_mag  = in_a[DW-1] ? (~$unsigned(in_a) + 1'b1) : $unsigned(in_a);
   assign b_mag  = in_b[DW-1] ? (~$unsigned(in_b) + 1'b1) : $unsigned(in_b);
   assign num_in = {a_mag, {FB{1'b0}}};

   // Decode the simple operations
   always_comb begin
      side_in               = '0;
      side_in.kind          = in_kind;
      side_in.a_less        = lt;
      side_in.a_greater     = gt;
      side_in.a_equal       = (in_a == in_b);
      side_in.product       = in_a * in_b;
      side_in.div_neg       = in_a[DW-1] ^ in_b[DW-1];
      side_in.div_zero      = (in_b == '0);
      side_in.simple_result = '0;
      side_in.simple_status = fpa_pkg::STATUS_OK;
      unique case (in_kind)
         fpa_pkg::KIND_ADD: begin
            side_in.simple_result = clamp_sum(add_s);
            if (add_s[DW] != add_s[DW-1]) side_in.simple_status = fpa_pkg::STATUS_SAT;
         end
         fpa_pkg::KIND_SUB: begin
            side_in.simple_result = clamp_sum(sub_s);
            if (sub_s[DW] != sub_s[DW-1]) side_in.simple_status = fpa_pkg::STATUS_SAT;
         end
         fpa_pkg::KIND_INC: begin
            side_in.simple_result = clamp_sum(inc_s);
            if (inc_s[DW] != inc_s[DW-1]) side_in.simple_status = fpa_pkg::STATUS_SAT;
         end
         fpa_pkg::KIND_DEC: begin
            side_in.simple_result = clamp_sum(dec_s);
            if (dec_s[DW] != dec_s[DW-1]) side_in.simple_status = fpa_pkg::STATUS_SAT;
         end
         fpa_pkg::KIND_MIN: side_in.simple_result = lt ? in_a : in_b;
         fpa_pkg::KIND_MAX: side_in.simple_result = gt ? in_a : in_b;
         fpa_pkg::KIND_FROM_INT: begin
            if (from_ovf) begin
               side_in.simple_result = in_a[DW-1] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
               side_in.simple_status = fpa_pkg::STATUS_SAT;
            end else begin
               side_in.simple_result = in_a <<< FB;
            end
         end
         fpa_pkg::KIND_TO_INT: side_in.simple_result = in_a >>> FB;
         default: side_in.simple_result = '0;
      endcase
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= b_mag;
      end
   end

endmodule

// ===== rtl/fpa_div_pipe.sv =====
module fpa_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  fpa_pkg::fpa_side_type         in_side,
   input  logic [fpa_pkg::NUM_W-1:0]     in_num,
   input  logic [fpa_pkg::DATA_W-1:0]    in_den,
   output logic                          out_valid,
   output fpa_pkg::fpa_side_type         out_side,
   output logic [fpa_pkg::NUM_W-1:0]     out_quot
);

   localparam int DW = fpa_pkg::DATA_W;
   localparam int NW = fpa_pkg::NUM_W;

   // Stage inputs; entry zero is the divider input
   logic                        valid_w [NW+1];
   fpa_pkg::fpa_side_type       side_w  [NW+1];
   logic [NW-1:0]               num_w   [NW+1];
   logic [DW-1:0]               den_w   [NW+1];
   logic [DW-1:0]               rem_w   [NW];

   assign valid_w[0] = in_valid;
   assign side_w[0]  = in_side;
   assign num_w[0]   = in_num;
   assign den_w[0]   = in_den;
   assign rem_w[0]   = '0;

   // One quotient bit per stage, restoring
   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW:0]              trial;
      logic [DW:0]              diff;
      logic                     fits;
      logic [DW-1:0]            rem_in;
      logic [NW-1:0]            num_in;
      logic                     valid_ff;
      fpa_pkg::fpa_side_type    side_ff;
      logic [NW-1:0]            num_ff;
      logic [DW-1:0]            den_ff;

      assign trial  = {rem_w[s], num_w[s][NW-1]};
      assign diff   = trial - {1'b0, den_w[s]};
      assign fits   = trial >= {1'b0, den_w[s]};
      assign rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
      assign num_in = {num_w[s][NW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff <= side_w[s];
            num_ff  <= num_in;
            den_ff  <= den_w[s];
         end
      end

      assign valid_w[s+1] = valid_ff;
      assign side_w[s+1]  = side_ff;
      assign num_w[s+1]   = num_ff;
      assign den_w[s+1]   = den_ff;

      // The last stage needs no remainder
      if (s < NW-1) begin : g_rem
         logic [DW-1:0] rem_ff;
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff <= rem_in;
            end
         end
         assign rem_w[s+1] = rem_ff;
      end
   end

   assign out_valid = valid_w[NW];
   assign out_side  = side_w[NW];
   assign out_quot  = num_w[NW];

endmodule

// ===== rtl/fpa_finish.sv =====
module fpa_finish (
   input  fpa_pkg::fpa_side_type         side,
   input  logic [fpa_pkg::NUM_W-1:0]     quot,
   output fpa_pkg::fpa_rsp_type          rsp
);

   localparam int DW = fpa_pkg::DATA_W;
   localparam int NW = fpa_pkg::NUM_W;
   localparam int PW = fpa_pkg::PROD_W;
   localparam int FB = fpa_pkg::FRACTION_BITS;
   localparam logic [PW-1:0] HALF = PW'(1) << (FB-1);

   logic [PW-1:0]            rsum;
   logic signed [PW-1:0]     rshift;
   logic [PW-DW:0]           mul_hi;
   logic                     mul_ovf;
   logic                     pos_ovf;
   logic                     neg_ovf;
   logic [DW-1:0]            quot_lo;

   // Round half away from zero: bias by half, less one for negatives
   assign rsum    = $unsigned(side.product) + HALF - PW'(side.product[PW-1]);
   assign rshift  = $signed(rsum) >>> FB;
   assign mul_hi  = rshift[PW-1:DW-1];
   assign mul_ovf = !((&mul_hi) || !(|mul_hi));

   // Quotient range check by sign
   assign quot_lo = quot[DW-1:0];
   assign pos_ovf = |quot[NW-1:DW-1];
   assign neg_ovf = (|quot[NW-1:DW]) || (quot[DW-1] && (|quot[DW-2:0]));

   // Select the result
   always_comb begin
      rsp.a_less    = side.a_less;
      rsp.a_greater = side.a_greater;
      rsp.a_equal   = side.a_equal;
      rsp.result    = side.simple_result;
      rsp.status    = side.simple_status;
      unique case (side.kind)
         fpa_pkg::KIND_MUL: begin
            if (mul_ovf) begin
               rsp.result = side.product[PW-1] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
               rsp.status = fpa_pkg::STATUS_SAT;
            end else begin
               rsp.result = rshift[DW-1:0];
               rsp.status = fpa_pkg::STATUS_OK;
            end
         end
         fpa_pkg::KIND_DIV: begin
            if (side.div_zero) begin
               rsp.result = '0;
               rsp.status = fpa_pkg::STATUS_DIV0;
            end else if (side.div_neg) begin
               rsp.result = neg_ovf ? fpa_pkg::SAT_MIN : $signed(~quot_lo + 1'b1);
               rsp.status = neg_ovf ? fpa_pkg::STATUS_SAT : fpa_pkg::STATUS_OK;
            end else begin
               rsp.result = pos_ovf ? fpa_pkg::SAT_MAX : $signed(quot_lo);
               rsp.status = pos_ovf ? fpa_pkg::STATUS_SAT : fpa_pkg::STATUS_OK;
            end
         end
         default: begin
            rsp.result = side.simple_result;
            rsp.status = side.simple_status;
         end
      endcase
   end

endmodule

// ===== rtl/fpa_out_queue.sv =====
module fpa_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fpa_pkg::fpa_rsp_type   push_data,
   input  logic                   pop,
   output logic                   has_room,
   output logic                   head_valid,
   output fpa_pkg::fpa_rsp_type   head_data
);

   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   fpa_pkg::fpa_rsp_type   entry0_ff;
   fpa_pkg::fpa_rsp_type   entry1_ff;

   assign has_room   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry0_ff;

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Entries: advance the second into the head on a pop
   always_ff @(posedge clock) begin
      if (pop) begin
         entry0_ff <= (push && count_ff == 2'd1) ? push_data : entry1_ff;
      end else if (push && count_ff == 2'd0) begin
         entry0_ff <= push_data;
      end
      if (push && ((count_ff == 2'd1 && !pop) || (count_ff == 2'd2))) begin
         entry1_ff <= push_data;
      end
   end

endmodule

// ===== rtl/fpa_checker.sv =====
module fpa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [fpa_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [fpa_pkg::DATA_W-1:0]   req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0]   req_operand_b,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [fpa_pkg::DATA_W-1:0]   rsp_result,
   input  logic                                rsp_a_less,
   input  logic                                rsp_a_greater,
   input  logic                                rsp_a_equal,
   input  logic [fpa_pkg::STATUS_W-1:0]        rsp_status
);

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   // Exactly one comparison outcome
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_greater, rsp_a_equal}))
      else $error("comparison flags not exclusive");

   // Divide by zero gives zero, and status is a defined code
   a_div0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == fpa_pkg::STATUS_DIV0) |-> (rsp_result == '0))
      else $error("divide by zero with nonzero result");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == fpa_pkg::STATUS_OK || rsp_status == fpa_pkg::STATUS_SAT
                     || rsp_status == fpa_pkg::STATUS_DIV0))
      else $error("undefined status code");

endmodule

bind fixed_point_alu_unit fpa_checker u_checker (.*);

// ===== test/tb_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps

module tb_fixed_point_alu_unit;

   localparam int LATENCY = 34 + fpa_pkg::FRACTION_BITS;

   // Opcodes outside the defined set
   localparam logic [fpa_pkg::KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
   localparam logic [fpa_pkg::KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

   typedef struct {
      logic [fpa_pkg::KIND_W-1:0]        kind;
      logic signed [fpa_pkg::DATA_W-1:0] a;
      logic signed [fpa_pkg::DATA_W-1:0] b;
      bit                                typed;
      fpa_pkg::fpa_rsp_type              rsp;
   } alu_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [fpa_pkg::KIND_W-1:0]           req_kind = '0;
   logic signed [fpa_pkg::DATA_W-1:0]    req_operand_a = '0;
   logic signed [fpa_pkg::DATA_W-1:0]    req_operand_b = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [fpa_pkg::DATA_W-1:0]    rsp_result;
   logic                                 rsp_a_less;
   logic                                 rsp_a_greater;
   logic                                 rsp_a_equal;
   logic [fpa_pkg::STATUS_W-1:0]         rsp_status;

   fpa_pkg::fpa_rsp_type   pending_rsp_q[$];
   alu_row_type            directed_rows[$];
   int                     mismatch_count = 0;
   bit                     hold_long = 1'b0;
   bit                     sender_done = 1'b0;

   fixed_point_alu_unit dut (.*);

   always #6 clock = ~clock;

   // Compute the expected response of one transaction
   function automatic fpa_pkg::fpa_rsp_type alu_predict(
         logic [fpa_pkg::KIND_W-1:0] kind,
         logic signed [fpa_pkg::DATA_W-1:0] a,
         logic signed [fpa_pkg::DATA_W-1:0] b);
      fpa_pkg::fpa_rsp_type r;
      longint sa, sb, p, wide, num;
      longint unsigned m, q;
      sa = a;
      sb = b;
      wide = 0;
      r.status = fpa_pkg::STATUS_OK;
      r.a_less = sa < sb;
      r.a_greater = sa > sb;
      r.a_equal = sa == sb;
      case (kind)
         fpa_pkg::KIND_ADD: wide = sa + sb;
         fpa_pkg::KIND_SUB: wide = sa - sb;
         fpa_pkg::KIND_MUL: begin
            p = sa * sb;
            m = (p < 0) ? -p : p;
            m = (m + (64'd1 << (fpa_pkg::FRACTION_BITS - 1))) >> fpa_pkg::FRACTION_BITS;
            wide = (p < 0) ? -longint'(m) : longint'(m);
         end
         fpa_pkg::KIND_DIV: begin
            if (sb == 0) begin
               r.status = fpa_pkg::STATUS_DIV0;
            end else begin
               num = sa <<< fpa_pkg::FRACTION_BITS;
               q = ((num < 0) ? -num : num) / ((sb < 0) ? -sb : sb);
               wide = ((num < 0) != (sb < 0)) ? -longint'(q) : longint'(q);
            end
         end
         fpa_pkg::KIND_MIN: wide = (sa < sb) ? sa : sb;
         fpa_pkg::KIND_MAX: wide = (sa > sb) ? sa : sb;
         fpa_pkg::KIND_INC: wide = sa + 1;
         fpa_pkg::KIND_DEC: wide = sa - 1;
         fpa_pkg::KIND_FROM_INT: wide = sa <<< fpa_pkg::FRACTION_BITS;
         fpa_pkg::KIND_TO_INT: wide = sa >>> fpa_pkg::FRACTION_BITS;
         default: wide = 0;
      endcase
      // Clamp to the 32-bit range
      if (wide > longint'(fpa_pkg::SAT_MAX)) begin
         wide = fpa_pkg::SAT_MAX;
         r.status = fpa_pkg::STATUS_SAT;
      end else if (wide < longint'(fpa_pkg::SAT_MIN)) begin
         wide = fpa_pkg::SAT_MIN;
         r.status = fpa_pkg::STATUS_SAT;
      end
      r.result = wide[fpa_pkg::DATA_W-1:0];
      return r;
   endfunction

   function automatic fpa_pkg::fpa_rsp_type typed_rsp(
         logic signed [fpa_pkg::DATA_W-1:0] res,
         bit lt, bit gt, bit eq,
         logic [fpa_pkg::STATUS_W-1:0] st);
      fpa_pkg::fpa_rsp_type r;
      r.result = res;
      r.a_less = lt;
      r.a_greater = gt;
      r.a_equal = eq;
      r.status = st;
      return r;
   endfunction

   function automatic void add_row(logic [fpa_pkg::KIND_W-1:0] kind,
                                   logic signed [fpa_pkg::DATA_W-1:0] a,
                                   logic signed [fpa_pkg::DATA_W-1:0] b, bit typed,
                                   fpa_pkg::fpa_rsp_type rsp);
      alu_row_type row;
      row.kind = kind;
      row.a = a;
      row.b = b;
      row.typed = typed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [fpa_pkg::KIND_W-1:0] random_kind();
      // Mostly defined opcodes, now and then an unused one
      return ($urandom_range(0, 15) == 0) ?
             fpa_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)) :
             fpa_pkg::KIND_W'($urandom_range(fpa_pkg::KIND_ADD, fpa_pkg::KIND_TO_INT));
   endfunction

   function automatic logic signed [fpa_pkg::DATA_W-1:0] random_operand();
      case ($urandom_range(0, 5))
         0: return fpa_pkg::SAT_MAX - fpa_pkg::DATA_W'($urandom_range(0, 3));
         1: return fpa_pkg::SAT_MIN + fpa_pkg::DATA_W'($urandom_range(0, 3));
         2: return fpa_pkg::DATA_W'(int'($urandom_range(0, 8192)) - 4096);
         3: return fpa_pkg::DATA_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   // Drive one transaction and hold it until accepted
   task automatic send_item(logic [fpa_pkg::KIND_W-1:0] kind,
                            logic signed [fpa_pkg::DATA_W-1:0] a,
                            logic signed [fpa_pkg::DATA_W-1:0] b, bit typed,
                            fpa_pkg::fpa_rsp_type rsp);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp_q.push_back(typed ? rsp : alu_predict(kind, a, b));
   endtask

   // Stimulus
   initial begin
      alu_row_type row;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Saturation, divide by zero, extremes
      add_row(fpa_pkg::KIND_ADD, fpa_pkg::SAT_MAX, 1, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 0, 1, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_ADD, fpa_pkg::SAT_MIN, -1, 1,
              typed_rsp(fpa_pkg::SAT_MIN, 1, 0, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_SUB, fpa_pkg::SAT_MIN, 1, 1,
              typed_rsp(fpa_pkg::SAT_MIN, 1, 0, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_SUB, fpa_pkg::SAT_MAX, -1, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 0, 1, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_MUL, fpa_pkg::SAT_MAX, fpa_pkg::SAT_MAX, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 0, 0, 1, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_MUL, fpa_pkg::SAT_MIN, fpa_pkg::SAT_MAX, 1,
              typed_rsp(fpa_pkg::SAT_MIN, 1, 0, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_MUL, 32'sd384, 32'sd384, 0, '0);
      add_row(fpa_pkg::KIND_MUL, 32'sd1, 32'sd128, 0, '0);
      add_row(fpa_pkg::KIND_MUL, -32'sd1, 32'sd128, 0, '0);
      add_row(fpa_pkg::KIND_DIV, 32'sd1000, 0, 1,
              typed_rsp(0, 0, 1, 0, fpa_pkg::STATUS_DIV0));
      add_row(fpa_pkg::KIND_DIV, fpa_pkg::SAT_MIN, -1, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 1, 0, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_DIV, fpa_pkg::SAT_MAX, 1, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 0, 1, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_DIV, -32'sd768, 32'sd512, 0, '0);
      add_row(fpa_pkg::KIND_MIN, 32'sd5, 32'sd5, 1,
              typed_rsp(5, 0, 0, 1, fpa_pkg::STATUS_OK));
      add_row(fpa_pkg::KIND_MAX, fpa_pkg::SAT_MIN, fpa_pkg::SAT_MAX, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 1, 0, 0, fpa_pkg::STATUS_OK));
      add_row(fpa_pkg::KIND_MIN, fpa_pkg::SAT_MIN, fpa_pkg::SAT_MAX, 1,
              typed_rsp(fpa_pkg::SAT_MIN, 1, 0, 0, fpa_pkg::STATUS_OK));
      add_row(fpa_pkg::KIND_INC, fpa_pkg::SAT_MAX, 0, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 0, 1, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_DEC, fpa_pkg::SAT_MIN, 0, 1,
              typed_rsp(fpa_pkg::SAT_MIN, 1, 0, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_FROM_INT, 32'sh0080_0000, 0, 1,
              typed_rsp(fpa_pkg::SAT_MAX, 0, 1, 0, fpa_pkg::STATUS_SAT));
      add_row(fpa_pkg::KIND_FROM_INT, -32'sd3, 0, 0, '0);
      add_row(fpa_pkg::KIND_TO_INT, -32'sd1, 0, 1,
              typed_rsp(-1, 1, 0, 0, fpa_pkg::STATUS_OK));
      add_row(fpa_pkg::KIND_TO_INT, fpa_pkg::SAT_MAX, fpa_pkg::SAT_MIN, 0, '0);
      add_row(KIND_UNUSED_HI, -32'sd1, -32'sd1, 1,
              typed_rsp(0, 0, 0, 1, fpa_pkg::STATUS_OK));
      add_row(KIND_UNUSED_LO, 32'sd0, 32'sd7, 1,
              typed_rsp(0, 1, 0, 0, fpa_pkg::STATUS_OK));
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.kind, row.a, row.b, row.typed, row.rsp);
      end
      // Random transactions
      for (int n = 0; n < 1750; n++) begin
         if (n == 300) hold_long = 1'b1;
         send_item(random_kind(), random_operand(),
                   ($urandom_range(0, 15) == 0) ? '0 : random_operand(), 0, '0);
      end
      req_valid <= 1'b0;
      sender_done = 1'b1;
   end

   // Receiver stall, with one long hold-off to fill the pipe
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_stall <= 1'b1;
            repeat (120) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall && $urandom_range(0, 1)) begin
            hold = $urandom_range(0, 3);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      fpa_pkg::fpa_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", rsp_result);
         end else begin
            exp_rsp = pending_rsp_q.pop_front();
            if (rsp_result !== exp_rsp.result || rsp_a_less !== exp_rsp.a_less ||
                rsp_a_greater !== exp_rsp.a_greater || rsp_a_equal !== exp_rsp.a_equal ||
                rsp_status !== exp_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %h %b%b%b st %0d, got %h %b%b%b st %0d",
                           exp_rsp.result, exp_rsp.a_less, exp_rsp.a_greater,
                           exp_rsp.a_equal, exp_rsp.status, rsp_result, rsp_a_less,
                           rsp_a_greater, rsp_a_equal, rsp_status);
            end
         end
      end
   end

   // Drain and report
   initial begin
      wait (sender_done);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[fixed_point_alu_unit] OK");
      end else begin
         $display("[fixed_point_alu_unit] ERROR");
      end
      $finish;
   end

   // Timeout
   initial begin
      #2000000;
      $display("[fixed_point_alu_unit] ERROR");
      $finish;
   end

endmodule
